FILE: rtl/phtr_pkg.sv
package phtr_pkg;

   localparam int DEF_RING_DEPTH = 1024;
   localparam int DEF_NUM_TAGS   = 64;
   localparam int RESULT_CAP     = 64;

   localparam int MODE_W   = 1;
   localparam int TAG_IN_W = 6;
   localparam int VALUE_W  = 64;
   localparam int QUAL_W   = 8;
   localparam int TIME_W   = 48;
   localparam int LIMIT_W  = 7;
   localparam int REC_W    = VALUE_W + QUAL_W + TIME_W;

   localparam logic [LIMIT_W-1:0] MAX_POINTS_RST = LIMIT_W'(RESULT_CAP);

   localparam logic [MODE_W-1:0] MODE_WRITE = 1'b0;
   localparam logic [MODE_W-1:0] MODE_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [QUAL_W-1:0]  quality;
      logic [TIME_W-1:0]  stamp;
   } record_type;

endpackage

FILE: rtl/phtr_ram.sv
module phtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/phtr_cmp.sv
module phtr_cmp (
   input  logic [phtr_pkg::TIME_W-1:0] stamp,
   input  logic [phtr_pkg::TIME_W-1:0] win_start,
   input  logic [phtr_pkg::TIME_W-1:0] win_end,
   output logic                        match
);
   import phtr_pkg::*;

   // Both window bounds are inclusive.
   assign match = (stamp >= win_start) && (stamp <= win_end);

endmodule

FILE: rtl/per_tag_history_ring_query_top.sv
// Per-tag history ring with a time-window query. Each tag keeps its last RING_DEPTH
// words (value, quality, timestamp); a write word stores one record and gives no
// result, a query word returns the matching records oldest first, at most max_points
// of them (a max_points of zero counts as one, and RESULT_CAP caps it), with last set
// on the final one, or a single word with hit clear when nothing matches. After reset
// the block clears its per-tag head and fill table before the first word is taken.
// A query scans up to RING_DEPTH stored records of its tag: one record per cycle is
// read from the record memory and checked against the window by the single compare
// unit, unless a stall on the result side holds the scan. The block takes no new
// word while a query is being scanned.
module per_tag_history_ring_query_top #(
   parameter int RING_DEPTH = phtr_pkg::DEF_RING_DEPTH,
   parameter int NUM_TAGS   = phtr_pkg::DEF_NUM_TAGS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [phtr_pkg::MODE_W-1:0]    req_mode,
   input  logic [phtr_pkg::TAG_IN_W-1:0]  req_tag_index,
   input  logic [phtr_pkg::VALUE_W-1:0]   req_sample_value,
   input  logic [phtr_pkg::QUAL_W-1:0]    req_sample_quality,
   input  logic [phtr_pkg::TIME_W-1:0]    req_sample_time,
   input  logic [phtr_pkg::TIME_W-1:0]    req_window_start,
   input  logic [phtr_pkg::TIME_W-1:0]    req_window_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_hit,
   output logic [phtr_pkg::VALUE_W-1:0]   rsp_found_value,
   output logic [phtr_pkg::QUAL_W-1:0]    rsp_found_quality,
   output logic [phtr_pkg::TIME_W-1:0]    rsp_found_time,
   output logic                           rsp_last,
   input  logic                           csr_write_enable,
   input  logic [phtr_pkg::LIMIT_W-1:0]   csr_write_data
);
   import phtr_pkg::*;

   localparam int POS_W  = $clog2(RING_DEPTH);
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int TAG_W  = NUM_TAGS > 1 ? $clog2(NUM_TAGS) : 1;
   localparam int TAGX_W = TAG_W + TAG_IN_W;
   localparam int SLOTS  = NUM_TAGS * RING_DEPTH;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int META_W = POS_W + CNT_W;

   state_type            state_ff, state_in;
   logic [TAG_W-1:0]     clr_ff, clr_in;
   logic [LIMIT_W-1:0]   max_points_ff, max_points_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic                 tag_ok_ff, tag_ok_in;
   logic [SLOT_W-1:0]    tag_base_ff, tag_base_in;
   record_type           wr_rec_ff, wr_rec_in;
   logic [TIME_W-1:0]    win_start_ff, win_start_in;
   logic [TIME_W-1:0]    win_end_ff, win_end_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [LIMIT_W-1:0]   hits_ff, hits_in;
   logic                 dv_ff, dv_in;
   logic                 pend_v_ff, pend_v_in;
   record_type           pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic                 rsp_last_ff, rsp_last_in;
   record_type           rsp_rec_ff, rsp_rec_in;

   logic [TAGX_W-1:0]    req_tag_wide;
   logic                 req_tag_ok;
   logic                 accept;
   logic [LIMIT_W-1:0]   limit;

   logic                 meta_we;
   logic [TAG_W-1:0]     meta_waddr;
   logic [META_W-1:0]    meta_wdata;
   logic [TAG_W-1:0]     meta_raddr;
   logic [META_W-1:0]    meta_rdata;
   logic [POS_W-1:0]     head;
   logic [CNT_W-1:0]     fill;
   logic [POS_W-1:0]     head_next;
   logic [CNT_W-1:0]     fill_next;
   logic [POS_W:0]       base_sum;
   logic [POS_W-1:0]     base_pos;

   logic                 rec_we;
   logic [SLOT_W-1:0]    rec_waddr;
   logic [SLOT_W-1:0]    rec_raddr;
   logic [REC_W-1:0]     rec_rdata;
   record_type           rd_rec;

   logic                 match_raw;
   logic                 match;
   logic                 out_free;
   logic                 scan_ok;
   logic                 stop;
   logic                 issue;

   assign req_tag_wide = {TAG_W'(0), req_tag_index};
   assign req_tag_ok   = req_tag_wide < TAGX_W'(NUM_TAGS);
   assign req_stall    = (state_ff != ST_IDLE);
   assign accept       = (state_ff == ST_IDLE) && req_valid;

   always_comb begin
      if (max_points_ff == '0) begin
         limit = LIMIT_W'(1);
      end else if (max_points_ff > LIMIT_W'(RESULT_CAP)) begin
         limit = LIMIT_W'(RESULT_CAP);
      end else begin
         limit = max_points_ff;
      end
   end

   // Head and fill table, one word per tag.
   assign head      = meta_rdata[META_W-1:CNT_W];
   assign fill      = meta_rdata[CNT_W-1:0];
   assign head_next = (head == POS_W'(RING_DEPTH - 1)) ? '0 : head + 1'b1;
   assign fill_next = (fill < CNT_W'(RING_DEPTH)) ? fill + 1'b1 : fill;
   assign base_sum  = {1'b0, head} + (POS_W + 1)'(RING_DEPTH) - (POS_W + 1)'(fill);
   assign base_pos  = (base_sum >= (POS_W + 1)'(RING_DEPTH))
                      ? POS_W'(base_sum - (POS_W + 1)'(RING_DEPTH))
                      : POS_W'(base_sum);

   assign meta_raddr = (state_ff == ST_IDLE) ? req_tag_wide[TAG_W-1:0] : tag_ff;

   always_comb begin
      meta_we    = 1'b0;
      meta_waddr = tag_ff;
      meta_wdata = {head_next, fill_next};
      if (state_ff == ST_CLEAR) begin
         meta_we    = 1'b1;
         meta_waddr = clr_ff;
         meta_wdata = '0;
      end else if (state_ff == ST_LOOKUP && mode_ff == MODE_WRITE && tag_ok_ff) begin
         meta_we = 1'b1;
      end
   end

   phtr_ram #(
      .WIDTH (META_W),
      .DEPTH (NUM_TAGS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (1'b1),
      .rd_addr (meta_raddr),
      .rd_data (meta_rdata)
   );

   // Record memory, one ring of RING_DEPTH records per tag.
   assign rec_we    = (state_ff == ST_LOOKUP) && (mode_ff == MODE_WRITE) && tag_ok_ff;
   assign rec_waddr = tag_base_ff + SLOT_W'(head);
   assign rec_raddr = tag_base_ff + SLOT_W'(pos_ff);
   assign rd_rec    = record_type'(rec_rdata);

   phtr_ram #(
      .WIDTH (REC_W),
      .DEPTH (SLOTS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (wr_rec_ff),
      .rd_en   (issue),
      .rd_addr (rec_raddr),
      .rd_data (rec_rdata)
   );

   phtr_cmp u_cmp (
      .stamp     (rd_rec.stamp),
      .win_start (win_start_ff),
      .win_end   (win_end_ff),
      .match     (match_raw)
   );

   assign match    = (state_ff == ST_SCAN) && dv_ff && match_raw;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign scan_ok  = !(match && pend_v_ff) || out_free;
   assign stop     = match && (hits_ff == limit - LIMIT_W'(1));
   assign issue    = (state_ff == ST_SCAN) && scan_ok && !stop && (rem_ff != '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == TAG_W'(NUM_TAGS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_tag_ok) begin
                  state_in = ST_LOOKUP;
               end else if (req_mode == MODE_QUERY) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_LOOKUP: begin
            if (mode_ff == MODE_WRITE) begin
               state_in = ST_IDLE;
            end else if (fill == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ok && (stop || rem_ff == '0)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      clr_in        = clr_ff;
      max_points_in = csr_write_enable ? csr_write_data : max_points_ff;
      mode_in       = mode_ff;
      tag_in        = tag_ff;
      tag_ok_in     = tag_ok_ff;
      tag_base_in   = tag_base_ff;
      wr_rec_in     = wr_rec_ff;
      win_start_in  = win_start_ff;
      win_end_in    = win_end_ff;
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      hits_in       = hits_ff;
      dv_in         = dv_ff;
      pend_v_in     = pend_v_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_hit_in    = rsp_hit_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_rec_in    = rsp_rec_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               mode_in           = req_mode;
               tag_in            = req_tag_wide[TAG_W-1:0];
               tag_ok_in         = req_tag_ok;
               tag_base_in       = SLOT_W'(SLOT_W'(req_tag_wide[TAG_W-1:0])
                                           * SLOT_W'(RING_DEPTH));
               wr_rec_in.value   = req_sample_value;
               wr_rec_in.quality = req_sample_quality;
               wr_rec_in.stamp   = req_sample_time;
               win_start_in      = req_window_start;
               win_end_in        = req_window_end;
               pend_v_in         = 1'b0;
            end
         end
         ST_LOOKUP: begin
            pos_in    = base_pos;
            rem_in    = fill;
            hits_in   = '0;
            dv_in     = 1'b0;
            pend_v_in = 1'b0;
         end
         ST_SCAN: begin
            if (scan_ok) begin
               dv_in = issue;
               if (issue) begin
                  rem_in = rem_ff - 1'b1;
                  pos_in = (pos_ff == POS_W'(RING_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
               end
               if (match) begin
                  // The previous match is known not to be the last one now.
                  hits_in   = hits_ff + 1'b1;
                  pend_in   = rd_rec;
                  pend_v_in = 1'b1;
                  if (pend_v_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_hit_in   = 1'b1;
                     rsp_last_in  = 1'b0;
                     rsp_rec_in   = pend_ff;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               pend_v_in    = 1'b0;
               if (pend_v_ff) begin
                  rsp_hit_in = 1'b1;
                  rsp_rec_in = pend_ff;
               end else begin
                  rsp_hit_in = 1'b0;
                  rsp_rec_in = '0;
               end
            end
         end
         default: begin
            dv_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         max_points_ff <= MAX_POINTS_RST;
         dv_ff         <= 1'b0;
         pend_v_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         max_points_ff <= max_points_in;
         dv_ff         <= dv_in;
         pend_v_ff     <= pend_v_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      tag_ff       <= tag_in;
      tag_ok_ff    <= tag_ok_in;
      tag_base_ff  <= tag_base_in;
      wr_rec_ff    <= wr_rec_in;
      win_start_ff <= win_start_in;
      win_end_ff   <= win_end_in;
      pos_ff       <= pos_in;
      rem_ff       <= rem_in;
      hits_ff      <= hits_in;
      pend_ff      <= pend_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_rec_ff   <= rsp_rec_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_found_value   = rsp_rec_ff.value;
   assign rsp_found_quality = rsp_rec_ff.quality;
   assign rsp_found_time    = rsp_rec_ff.stamp;
   assign rsp_last          = rsp_last_ff;

endmodule
